// ----- design/multi_pattern_byte_matcher_core_defines.svh -----
// Assertion helpers used by the matcher core design file.
`ifndef MULTI_PATTERN_BYTE_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_BYTE_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mpbm_pkg.sv -----
`timescale 1ns / 1ps

package mpbm_pkg;

	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int COUNT_W     = 3;
	localparam int PATTERN_REGS = 4;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_THREE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CFG_W-1:0]  pattern_t;

endpackage

// ----- design/mpbm_if.sv -----
`timescale 1ns / 1ps

interface mpbm_in_if
	import mpbm_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  op;
	byte_t rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface mpbm_out_if #(
	parameter int MATCH_W = 3
) ();
	logic               valid;
	logic               ready;
	logic [MATCH_W-1:0] matched_pattern;
	logic               search_done;

	modport source (output valid, output matched_pattern, output search_done, input ready);
	modport sink   (input valid, input matched_pattern, input search_done, output ready);
endinterface

// ----- design/multi_pattern_byte_matcher_core.sv -----
// Streaming matcher for up to NUM_PATTERNS zero-terminated byte patterns. Each request
// is a received byte or a restart; every request yields exactly one result with the
// number of the pattern it completed (0 for none) and the sticky done flag. A new
// request is taken every cycle unless the result channel stalls: it sits in the
// input register while all patterns are compared against it in parallel, then lands
// in the result register; throughput is one request per cycle. The result channel
// must be connected with MATCH_W = clog2(NUM_PATTERNS + 1). Write pattern registers
// only while no request is in flight.
`timescale 1ns / 1ps
`include "multi_pattern_byte_matcher_core_defines.svh"

module multi_pattern_byte_matcher_core
	import mpbm_pkg::*;
#(
	parameter int NUM_PATTERNS    = 4,
	parameter int MAX_PATTERN_LEN = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	mpbm_in_if.sink              rx,
	mpbm_out_if.source           res
);

	localparam int MATCH_W = $clog2(NUM_PATTERNS + 1);
	localparam int POS_W   = $clog2(MAX_PATTERN_LEN + 1);
	localparam int IDX_W   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	pattern_t             pattern_q [PATTERN_REGS];
	logic [COUNT_W-1:0]   count_q;
	logic [POS_W-1:0]     pos_q [NUM_PATTERNS];
	logic                 done_q;

	logic                 valid_s1;
	logic                 op_s1;
	byte_t                byte_s1;

	logic                 res_valid_q;
	logic [MATCH_W-1:0]   res_matched_q;
	logic                 res_done_q;

	logic                 res_free;
	logic                 adv_s1;
	logic                 rx_take;

	logic [NUM_PATTERNS-1:0] act;
	logic [NUM_PATTERNS-1:0] hit;
	logic [NUM_PATTERNS-1:0] upd;
	logic [POS_W-1:0]        pos_next [NUM_PATTERNS];
	logic                    hit_seen;
	logic [MATCH_W-1:0]      match_idx;
	logic                    scan;

	assign res_free  = !res_valid_q || res.ready;
	assign adv_s1    = valid_s1 && res_free;
	assign rx.ready  = !valid_s1 || res_free;
	assign rx_take   = rx.valid && rx.ready;
	assign scan      = (op_s1 == OP_BYTE) && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < PATTERN_REGS; r++) begin
				pattern_q[r] <= '0;
			end
			count_q <= COUNT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PATTERN_ZERO:  pattern_q[0] <= cfg_wdata;
				CFG_PATTERN_ONE:   pattern_q[1] <= cfg_wdata;
				CFG_PATTERN_TWO:   pattern_q[2] <= cfg_wdata;
				CFG_PATTERN_THREE: pattern_q[3] <= cfg_wdata;
				CFG_PATTERN_COUNT: count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_pat
		byte_t            pbytes [MAX_PATTERN_LEN];
		logic [POS_W-1:0] len;
		logic             in_range;
		logic             adv;
		byte_t            expected;

		for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_byte
			if (i < PATTERN_REGS) begin : g_reg
				assign pbytes[k] = pattern_q[i][BYTE_W*k +: BYTE_W];
			end else begin : g_empty
				assign pbytes[k] = '0;
			end
		end

		always_comb begin
			len = POS_W'(MAX_PATTERN_LEN);
			for (int k = MAX_PATTERN_LEN - 1; k >= 0; k--) begin
				if (pbytes[k] == '0) begin
					len = POS_W'(k);
				end
			end
		end

		assign act[i]      = int'(count_q) > i;
		assign in_range    = pos_q[i] < len;
		assign expected    = pbytes[pos_q[i][IDX_W-1:0]];
		assign adv         = in_range && (byte_s1 == expected);
		assign hit[i]      = act[i] && (len != '0) && adv && ((pos_q[i] + POS_W'(1)) == len);

		always_comb begin
			if (len == '0) begin
				pos_next[i] = '0;
			end else if (adv) begin
				pos_next[i] = pos_q[i] + POS_W'(1);
			end else if (byte_s1 == pbytes[0]) begin
				pos_next[i] = POS_W'(1);
			end else begin
				pos_next[i] = '0;
			end
		end
	end

	always_comb begin
		hit_seen  = 1'b0;
		match_idx = '0;
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			upd[i] = act[i] && !hit_seen;
			if (hit[i] && !hit_seen) begin
				match_idx = MATCH_W'(i + 1);
			end
			hit_seen = hit_seen | hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			op_s1   <= rx.op;
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				pos_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else if (adv_s1) begin
			if (op_s1 == OP_RESTART) begin
				for (int i = 0; i < NUM_PATTERNS; i++) begin
					pos_q[i] <= '0;
				end
				done_q <= 1'b0;
			end else if (!done_q) begin
				for (int i = 0; i < NUM_PATTERNS; i++) begin
					if (upd[i]) begin
						pos_q[i] <= pos_next[i];
					end
				end
				done_q <= hit_seen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_matched_q <= scan ? match_idx : '0;
			res_done_q    <= (op_s1 == OP_BYTE) && (done_q || hit_seen);
		end
	end

	assign res.valid           = res_valid_q;
	assign res.matched_pattern = res_matched_q;
	assign res.search_done     = res_done_q;

	`MPBM_ASSERT_NOW(a_match_sets_done, clk, arst_n,
		res_valid_q && (res_matched_q != '0), res_done_q, "match reported without done flag")
	`MPBM_ASSERT_NEXT(a_done_blocks_match, clk, arst_n,
		adv_s1 && done_q && (op_s1 == OP_BYTE),
		(res_matched_q == '0) && res_done_q && done_q, "byte after match changed the result")
	`MPBM_ASSERT_NEXT(a_restart_clears, clk, arst_n,
		adv_s1 && (op_s1 == OP_RESTART),
		!done_q && !res_done_q && (res_matched_q == '0), "restart left done flag set")
	`MPBM_ASSERT_NEXT(a_hit_sets_done, clk, arst_n,
		adv_s1 && scan && hit_seen, done_q && (res_matched_q != '0), "completed pattern lost")

endmodule
